/* rtl/core/bnsfn_pkg.sv */
// Package for the block number set: command codes, port width of block numbers
// and the lowest-set-bit encoder shared by the search logic.
// No dependencies.
package bnsfn_pkg;

	localparam int BLK_W = 16;

	typedef enum logic [1:0] {
		CMD_SET   = 2'd0,
		CMD_TEST  = 2'd1,
		CMD_NEXT  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	// Index of the lowest set bit, found by halving; an all-zero word gives 63.
	function automatic logic [5:0] lowest_bit(input logic [63:0] v);
		logic [5:0]  n;
		logic [63:0] t;
		n = '0;
		t = v;
		if (t[31:0] == 32'd0) begin
			n[5] = 1'b1;
			t = t >> 32;
		end
		if (t[15:0] == 16'd0) begin
			n[4] = 1'b1;
			t = t >> 16;
		end
		if (t[7:0] == 8'd0) begin
			n[3] = 1'b1;
			t = t >> 8;
		end
		if (t[3:0] == 4'd0) begin
			n[2] = 1'b1;
			t = t >> 4;
		end
		if (t[1:0] == 2'd0) begin
			n[1] = 1'b1;
			t = t >> 2;
		end
		if (t[0] == 1'b0) begin
			n[0] = 1'b1;
		end
		return n;
	endfunction

endpackage

/* rtl/core/bnsfn_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module bnsfn_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/core/block_number_set_find_next_top.sv */
// Top level of the block number set with find-next: two-level bitmap in two RAMs.
// Depends on bnsfn_pkg and bnsfn_ram.
//
// channel  direction  handshake              payload
// request  in         req_valid / req_stall  cmd, block, from_start
// result   out        rsp_valid / rsp_stall  hit, found_block
//
// Set and test run through accept with RAM read, read-modify-write, result register.
// Find next goes from read-modify-write to the result register when the start word
// holds a member, no word follows it or the start lies out of range; else it scans
// summary words in ST_SUM and reads the member word in ST_MEM when one holds a member;
// the summary RAM read port paces the scan. Clear sweeps every summary word to zero;
// a member word counts only while its summary bit is set, so only the summary RAM is
// swept. After reset the same sweep clears all SUMMARY_WORDS summary words (16 by
// default) with req_stall high. req_stall is high whenever a request is in progress;
// a stalled result holds the block in its result state.
module block_number_set_find_next_top
	import bnsfn_pkg::*;
#(
	parameter int BLOCK_BITS = 16,
	parameter int WORD_BITS  = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  logic [1:0]       cmd,
	input  logic [BLK_W-1:0] block,
	input  logic             from_start,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output logic             hit,
	output logic [BLK_W-1:0] found_block
);

	localparam int WL            = $clog2(WORD_BITS);
	localparam int MW_BITS       = BLOCK_BITS - WL;
	localparam int SW_BITS       = (MW_BITS > WL) ? (MW_BITS - WL) : 0;
	localparam int SA_BITS       = (SW_BITS > 0) ? SW_BITS : 1;
	localparam int MEMBER_WORDS  = 2 ** MW_BITS;
	localparam int SUMMARY_WORDS = 2 ** SW_BITS;
	localparam int EW            = ((BLOCK_BITS > BLK_W) ? BLOCK_BITS : BLK_W) + 1;
	localparam int MF_BITS       = SA_BITS + WL;
	localparam logic [SA_BITS-1:0]   SW_LAST = SA_BITS'(SUMMARY_WORDS - 1);
	localparam logic [WORD_BITS-1:0] ONES    = '1;
	localparam logic [WORD_BITS-1:0] ONE     = WORD_BITS'(1);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_CLR  = 6'b000010,
		ST_EXEC = 6'b000100,
		ST_SUM  = 6'b001000,
		ST_MEM  = 6'b010000,
		ST_RESP = 6'b100000
	} state_t;

	state_t                 state_q;
	cmd_t                   cmd_q;
	logic [BLOCK_BITS-1:0]  pos_q;
	logic                   rng_q;
	logic [SA_BITS-1:0]     scan_sw_q;
	logic [WL-1:0]          scan_sb_q;
	logic [MW_BITS-1:0]     mw_q;
	logic [SA_BITS-1:0]     clr_cnt_q;
	logic                   clr_resp_q;
	logic                   res_hit_q;
	logic [BLOCK_BITS-1:0]  res_found_q;
	logic                   rsp_valid_q;
	logic                   hit_q;
	logic [BLK_W-1:0]       found_q;

	logic                   mem_we, mem_re, sum_we, sum_re;
	logic [MW_BITS-1:0]     mem_waddr, mem_raddr;
	logic [WORD_BITS-1:0]   mem_wdata, mem_rdata;
	logic [SA_BITS-1:0]     sum_waddr, sum_raddr;
	logic [WORD_BITS-1:0]   sum_wdata, sum_rdata;

	logic [EW-1:0]          tgt;
	logic [BLOCK_BITS-1:0]  in_pos;
	logic                   in_rng;
	logic [MW_BITS-1:0]     in_w;
	logic [SA_BITS-1:0]     in_sw;

	logic [MW_BITS-1:0]     cur_w;
	logic [WL-1:0]          cur_b;
	logic [SA_BITS-1:0]     cur_sw;
	logic [WL-1:0]          cur_sb;
	logic                   word_ok;
	logic [WORD_BITS-1:0]   masked;
	logic [MW_BITS:0]       nxt_w;
	logic [SA_BITS-1:0]     nxt_sw;
	logic [WL-1:0]          nxt_sb;
	logic [WORD_BITS-1:0]   scan_bits;
	logic [MF_BITS-1:0]     scan_mw;
	logic                   scan_mw_ok;
	logic                   scan_last;

	always_comb begin
		if (cmd_t'(cmd) == CMD_NEXT) begin
			tgt = from_start ? '0 : EW'(block) + EW'(1);
		end else begin
			tgt = EW'(block);
		end
	end

	assign in_pos = tgt[BLOCK_BITS-1:0];
	assign in_rng = (tgt >> BLOCK_BITS) == EW'(0);
	assign in_w   = in_pos[BLOCK_BITS-1:WL];
	assign in_sw  = SA_BITS'(in_w >> WL);

	assign cur_w      = pos_q[BLOCK_BITS-1:WL];
	assign cur_b      = pos_q[WL-1:0];
	assign cur_sw     = SA_BITS'(cur_w >> WL);
	assign cur_sb     = WL'(cur_w);
	assign word_ok    = sum_rdata[cur_sb];
	assign masked     = (word_ok ? mem_rdata : '0) & (ONES << cur_b);
	assign nxt_w      = {1'b0, cur_w} + (MW_BITS + 1)'(1);
	assign nxt_sw     = SA_BITS'(nxt_w[MW_BITS-1:0] >> WL);
	assign nxt_sb     = WL'(nxt_w[MW_BITS-1:0]);
	assign scan_bits  = sum_rdata & (ONES << scan_sb_q);
	assign scan_mw    = (MF_BITS'(scan_sw_q) << WL)
		| MF_BITS'(WL'(lowest_bit(64'(scan_bits))));
	assign scan_mw_ok = (scan_mw >> MW_BITS) == MF_BITS'(0);
	assign scan_last  = scan_sw_q == SW_LAST;

	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = in_w;
		mem_we    = 1'b0;
		mem_waddr = cur_w;
		mem_wdata = (word_ok ? mem_rdata : '0) | (ONE << cur_b);
		sum_re    = 1'b0;
		sum_raddr = in_sw;
		sum_we    = 1'b0;
		sum_waddr = cur_sw;
		sum_wdata = sum_rdata | (ONE << cur_sb);
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					mem_re = 1'b1;
					sum_re = 1'b1;
				end
			end
			ST_CLR: begin
				sum_we    = 1'b1;
				sum_waddr = clr_cnt_q;
				sum_wdata = '0;
			end
			ST_EXEC: begin
				if (cmd_q == CMD_SET && rng_q) begin
					mem_we = 1'b1;
					sum_we = 1'b1;
				end else if (cmd_q == CMD_NEXT && rng_q && masked == '0 && !nxt_w[MW_BITS]) begin
					sum_re    = 1'b1;
					sum_raddr = nxt_sw;
				end
			end
			ST_SUM: begin
				if (scan_bits != '0) begin
					if (scan_mw_ok) begin
						mem_re    = 1'b1;
						mem_raddr = MW_BITS'(scan_mw);
					end
				end else if (!scan_last) begin
					sum_re    = 1'b1;
					sum_raddr = scan_sw_q + SA_BITS'(1);
				end
			end
			ST_MEM, ST_RESP: begin
			end
			default: begin
			end
		endcase
	end

	bnsfn_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(MEMBER_WORDS),
		.AW   (MW_BITS)
	) u_member_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	bnsfn_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(SUMMARY_WORDS),
		.AW   (SA_BITS)
	) u_summary_ram (
		.clk  (clk),
		.we   (sum_we),
		.waddr(sum_waddr),
		.wdata(sum_wdata),
		.re   (sum_re),
		.raddr(sum_raddr),
		.rdata(sum_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_cnt_q   <= '0;
			clr_resp_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall && state_q != ST_RESP) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						cmd_q       <= cmd_t'(cmd);
						pos_q       <= in_pos;
						rng_q       <= in_rng;
						res_hit_q   <= 1'b0;
						res_found_q <= '0;
						if (cmd_t'(cmd) == CMD_CLEAR) begin
							clr_cnt_q  <= '0;
							clr_resp_q <= 1'b1;
							state_q    <= ST_CLR;
						end else begin
							state_q <= ST_EXEC;
						end
					end
				end
				ST_CLR: begin
					clr_cnt_q <= clr_cnt_q + SA_BITS'(1);
					if (clr_cnt_q == SW_LAST) begin
						state_q <= clr_resp_q ? ST_RESP : ST_IDLE;
					end
				end
				ST_EXEC: begin
					if (cmd_q == CMD_NEXT && rng_q && masked == '0 && !nxt_w[MW_BITS]) begin
						scan_sw_q <= nxt_sw;
						scan_sb_q <= nxt_sb;
						state_q   <= ST_SUM;
					end else begin
						state_q <= ST_RESP;
					end
					case (cmd_q)
						CMD_TEST: begin
							res_hit_q <= rng_q & word_ok & mem_rdata[cur_b];
						end
						CMD_NEXT: begin
							if (rng_q && masked != '0) begin
								res_hit_q   <= 1'b1;
								res_found_q <= {cur_w, WL'(lowest_bit(64'(masked)))};
							end
						end
						default: begin
						end
					endcase
				end
				ST_SUM: begin
					if (scan_bits != '0) begin
						if (scan_mw_ok) begin
							mw_q    <= MW_BITS'(scan_mw);
							state_q <= ST_MEM;
						end else begin
							state_q <= ST_RESP;
						end
					end else if (scan_last) begin
						state_q <= ST_RESP;
					end else begin
						scan_sw_q <= scan_sw_q + SA_BITS'(1);
						scan_sb_q <= '0;
					end
				end
				ST_MEM: begin
					if (mem_rdata != '0) begin
						res_hit_q   <= 1'b1;
						res_found_q <= {mw_q, WL'(lowest_bit(64'(mem_rdata)))};
					end
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_valid_q <= 1'b1;
						hit_q       <= res_hit_q;
						found_q     <= BLK_W'(res_found_q);
						clr_resp_q  <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign req_stall   = state_q != ST_IDLE;
	assign rsp_valid   = rsp_valid_q;
	assign hit         = hit_q;
	assign found_block = found_q;

`ifndef SYNTHESIS
	a_exec_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EXEC |-> $past(state_q == ST_IDLE && req_valid))
		else $error("request execution without an accepted request");

	a_resp_loads: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RESP && !rsp_valid_q |=> rsp_valid_q && state_q == ST_IDLE)
		else $error("result not loaded into a free output slot");

	a_member_write: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> sum_we && cmd_q == CMD_SET && state_q == ST_EXEC)
		else $error("member write without matching summary update");
`endif

endmodule
